[src/torus_mass_loading_source_macros.svh]
// Assertion macros for the torus mass-loading source.
`ifndef TORUS_MASS_LOADING_SOURCE_MACROS_SVH
`define TORUS_MASS_LOADING_SOURCE_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define TMLS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("torus source assertion failed");
// Checked property that also holds during reset.
`define TMLS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("torus source assertion failed");
`else
`define TMLS_ASSERT(label, clk, rst, prop)
`define TMLS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[src/tmls_pkg.sv]
// Shared constants and types for the torus mass-loading source.
`default_nettype none
package tmls_pkg;

  // Cosine evaluation runs in Q2.30.
  localparam int Q30_BITS = 30;
  localparam logic [31:0] PI_Q30 = 32'd3373259425;

  // Taylor coefficients (-1)^k/(2k)! in Q30, lowest order first.
  localparam logic signed [33:0] COS_COEF [7] = '{
    34'sd1073741824, -34'sd536870912, 34'sd44739243, -34'sd1491308,
    34'sd26631, -34'sd296, 34'sd2
  };

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_RING   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TUBE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIPOLE = 3'd4;

  // Side information that travels beside the velocity dividers.
  typedef struct packed {
    logic azero;
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
  } vel_flags_t;

endpackage
`default_nettype wire

[src/tmls_delay.sv]
// Enabled shift line that delays a word through a chain of registers.
`default_nettype none
module tmls_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [N];

  // Every tap moves one place when the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < N; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[N-1];

endmodule
`default_nettype wire

[src/tmls_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tmls_isqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] din,
  output logic [RW-1:0]   root
);

  logic [RW:0]     rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] n_q    [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW:0]     rem_in;
    logic [RW-1:0]   root_in;
    logic [2*RW-1:0] n_in;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = din;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign n_in    = n_q[j-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_in, n_in[2*RW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_q[j]  <= diff[RW:0];
          root_q[j] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh[RW:0];
          root_q[j] <= {root_in[RW-2:0], 1'b0};
        end
        n_q[j] <= {n_in[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule
`default_nettype wire

[src/tmls_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tmls_div #(
  parameter int ND = 64,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [ND-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q
);

  localparam int W = DW + QW;

  logic [W-1:0]  rem_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic [DW-1:0] d_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [W-1:0]  rem_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] d_in;
    logic [W-1:0]  dsh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = W'(n);
      assign q_in   = '0;
      assign d_in   = d;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign d_in   = d_q[k-1];
    end

    // Subtract the shifted divisor when it fits.
    assign dsh = W'(d_in) << B;
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? rem_in - dsh : rem_in;
        q_q[k]   <= {q_in[QW-2:0], ge};
        d_q[k]   <= d_in;
      end
    end
  end

  assign q = q_q[QW-1];

endmodule
`default_nettype wire

[src/tmls_cos.sv]
// Raised-cosine profile (1 - cos(pi*t)) / 2 as a ten-stage pipeline.
`default_nettype none
module tmls_cos
  import tmls_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [FRAC_BITS:0] t,
  output logic [FRAC_BITS:0] w
);

  localparam int SH = Q30_BITS - FRAC_BITS;
  localparam logic [30:0] HALF_Q30 = 31'd1 << (Q30_BITS - 1);
  localparam logic [30:0] ONE_Q30 = 31'd1 << Q30_BITS;
  localparam logic [31:0] ROUND_HALF = 32'd1 << (SH - 1);
  localparam logic signed [66:0] TRUNC_BIAS = (67'sd1 <<< Q30_BITS) - 67'sd1;

  // Fold the argument into the first quarter turn.
  logic [30:0] s_full;
  logic [30:0] s_sel;
  logic        s_flip;
  logic [29:0] s0;
  logic        flip0;

  assign s_full = 31'(t) << SH;
  assign s_flip = s_full > HALF_Q30;
  assign s_sel  = s_flip ? ONE_Q30 - s_full : s_full;

  always_ff @(posedge clk) begin
    if (en) begin
      s0    <= s_sel[29:0];
      flip0 <= s_flip;
    end
  end

  // Angle phi = s * pi.
  logic [61:0] pphi;
  logic [30:0] phi1;
  logic        flip1;

  assign pphi = 62'(s0) * 62'(PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      phi1  <= pphi[60:30];
      flip1 <= flip0;
    end
  end

  // Square of the angle.
  logic [61:0] pq;
  logic [31:0] q2;
  logic        flip2;

  assign pq = 62'(phi1) * 62'(phi1);

  always_ff @(posedge clk) begin
    if (en) begin
      q2    <= pq[61:30];
      flip2 <= flip1;
    end
  end

  // Horner steps, one coefficient per stage, products truncated toward zero.
  logic signed [33:0] acc_q  [6];
  logic [31:0]        q_q    [6];
  logic               flip_q [6];

  for (genvar h = 0; h < 6; h++) begin : g_horner
    logic signed [33:0] acc_in;
    logic [31:0]        q_in;
    logic               flip_in;
    logic signed [66:0] prod;
    logic signed [66:0] adj;
    logic signed [66:0] quot;

    if (h == 0) begin : g_first
      assign acc_in  = COS_COEF[6];
      assign q_in    = q2;
      assign flip_in = flip2;
    end else begin : g_next
      assign acc_in  = acc_q[h-1];
      assign q_in    = q_q[h-1];
      assign flip_in = flip_q[h-1];
    end

    assign prod = 67'(acc_in) * 67'($signed({1'b0, q_in}));
    assign adj  = prod[66] ? prod + TRUNC_BIAS : prod;
    assign quot = adj >>> Q30_BITS;

    always_ff @(posedge clk) begin
      if (en) begin
        acc_q[h]  <= COS_COEF[5-h] + quot[33:0];
        q_q[h]    <= q_in;
        flip_q[h] <= flip_in;
      end
    end
  end

  // Halve 1 - cos, clamp to [0, 1] and round to the output fraction.
  logic signed [33:0] cosv;
  logic signed [34:0] dsub;
  logic signed [34:0] half;
  logic [30:0]        wc;
  logic [31:0]        wsum;

  assign cosv = flip_q[5] ? -acc_q[5] : acc_q[5];
  assign dsub = $signed({4'b0, ONE_Q30}) - 35'(cosv);
  assign half = dsub[34] ? (dsub + 35'sd1) >>> 1 : dsub >>> 1;

  always_comb begin
    if (half[34]) begin
      wc = '0;
    end else if (half > $signed({4'b0, ONE_Q30})) begin
      wc = ONE_Q30;
    end else begin
      wc = half[30:0];
    end
  end

  assign wsum = 32'(wc) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      w <= wsum[SH +: FRAC_BITS+1];
    end
  end

endmodule
`default_nettype wire

[src/torus_mass_loading_source.sv]
// Throughput: one cell per cycle while the skid entry is empty, through two 32-stage
// square roots and pipelined dividers.
// The output register plus one skid entry absorb a stalled result; the pipeline then holds.
// Reset clears the stage valid bits, output and skid state, and loads register defaults.
// No clearing pass follows reset.
`default_nettype none
`include "torus_mass_loading_source_macros.svh"
module torus_mass_loading_source
  import tmls_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [31:0]            wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            x_coord,
  input  logic [31:0]            y_coord,
  input  logic [31:0]            z_coord,
  input  logic [30:0]            cell_volume,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            mass_source,
  output logic [31:0]            momentum_x_source,
  output logic [31:0]            momentum_y_source,
  output logic                   inside_torus
);

  localparam int LAT = 88 + FRAC_BITS;
  localparam logic [63:0] QHALF = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] LIM31 = 64'h0000_0000_8000_0000;
  localparam logic [31:0] SMAX = 32'h7fff_ffff;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  // Product rounded half away from zero and saturated to 32 bits.
  function automatic logic [31:0] qround(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [63:0] mr;
    mag = p[63] ? 64'(-p) : 64'(p);
    mr  = (mag + QHALF) >> FRAC_BITS;
    if (p[63]) begin
      return (mr >= LIM31) ? SMIN : 32'(-mr);
    end
    return (mr >= LIM31) ? SMAX : mr[31:0];
  endfunction

  // Signed velocity from a quotient magnitude, saturated to 32 bits.
  function automatic logic [31:0] velsat(input logic [31:0] qm, input logic neg,
                                         input logic ovf);
    if (ovf) begin
      return neg ? SMIN : SMAX;
    end
    if (neg) begin
      return (qm > SMIN) ? SMIN : -qm;
    end
    return (qm > SMAX) ? SMAX : qm;
  endfunction

  // Configuration registers.
  logic [30:0] ring;
  logic [30:0] tube;
  logic [31:0] speed;
  logic [31:0] rate;
  logic        dip;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring  <= 31'd386662;
      tube  <= 31'd65536;
      speed <= 32'd65536;
      rate  <= 32'd65536;
      dip   <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        REG_RING:   ring  <= wr_data[30:0];
        REG_TUBE:   tube  <= wr_data[30:0];
        REG_SPEED:  speed <= wr_data;
        REG_RATE:   rate  <= wr_data;
        REG_DIPOLE: dip   <= wr_data[0];
        default:    ;
      endcase
    end
  end

  // Pipeline control: every stage advances unless the skid entry is occupied.
  logic           skid_full;
  logic           en;
  logic [LAT-1:0] vld;

  assign en       = !skid_full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage 1: capture the cell and take coordinate magnitudes.
  logic [31:0] x1, y1, ax1, ay1, az1;
  logic [30:0] vol1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= x_coord;
      y1   <= y_coord;
      ax1  <= x_coord[31] ? -x_coord : x_coord;
      ay1  <= y_coord[31] ? -y_coord : y_coord;
      az1  <= z_coord[31] ? -z_coord : z_coord;
      vol1 <= cell_volume;
    end
  end

  // Stages 2 and 3: x^2 + y^2.
  logic [63:0] sqx2, sqy2, sum3;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= {32'b0, ax1} * {32'b0, ax1};
      sqy2 <= {32'b0, ay1} * {32'b0, ay1};
      sum3 <= sqx2 + sqy2;
    end
  end

  // Cylindrical radius.
  logic [31:0] a35;

  tmls_isqrt #(.RW(32)) u_sqrt_a (
    .clk(clk), .en(en), .din(sum3), .root(a35)
  );

  logic [31:0] x35, y35, az35;

  tmls_delay #(.W(96), .N(34)) u_dly_xyz (
    .clk(clk), .en(en), .din({x1, y1, az1}), .dout({x35, y35, az35})
  );

  // Stages 36 to 38: (a - ring)^2 + z^2.
  logic [31:0] dm36, az36, a36;
  logic [63:0] sqd37, sqz37, sum38;

  always_ff @(posedge clk) begin
    if (en) begin
      dm36  <= (a35 >= {1'b0, ring}) ? a35 - {1'b0, ring} : {1'b0, ring} - a35;
      az36  <= az35;
      a36   <= a35;
      sqd37 <= {32'b0, dm36} * {32'b0, dm36};
      sqz37 <= {32'b0, az36} * {32'b0, az36};
      sum38 <= sqd37 + sqz37;
    end
  end

  // Distance to the centre ring.
  logic [31:0] r70;

  tmls_isqrt #(.RW(32)) u_sqrt_r (
    .clk(clk), .en(en), .din(sum38), .root(r70)
  );

  // Stage 71: tube test and numerator of the normalized depth.
  logic                      in_tube;
  logic [30:0]               depth;
  logic                      in71;
  logic [30+FRAC_BITS:0]     num71;

  assign in_tube = dip && (tube != '0) && ({1'b0, tube} >= r70);
  assign depth   = tube - r70[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      in71  <= in_tube;
      num71 <= in_tube ? {depth, {FRAC_BITS{1'b0}}} : '0;
    end
  end

  // Normalized depth t in [0, 1].
  logic [FRAC_BITS:0] tq;

  tmls_div #(.ND(31 + FRAC_BITS), .DW(31), .QW(FRAC_BITS + 1)) u_div_t (
    .clk(clk), .en(en), .n(num71), .d(tube), .q(tq)
  );

  logic [FRAC_BITS:0] wq;

  tmls_cos #(.FRAC_BITS(FRAC_BITS)) u_cos (
    .clk(clk), .en(en), .t(tq), .w(wq)
  );

  // Velocity path: products V*y and V*x against the radius.
  logic [63:0] pvy36, pvx36;
  logic [63:0] ny, nx;
  logic [63:0] ny37, nx37;
  logic [31:0] a37;
  vel_flags_t  fl37;

  always_ff @(posedge clk) begin
    if (en) begin
      pvy36 <= {{32{speed[31]}}, speed} * {{32{y35[31]}}, y35};
      pvx36 <= {{32{speed[31]}}, speed} * {{32{x35[31]}}, x35};
    end
  end

  assign ny = pvy36[63] ? -pvy36 : pvy36;
  assign nx = pvx36[63] ? -pvx36 : pvx36;

  // Quotients of 2^32 or more saturate whatever their sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ny37        <= ny;
      nx37        <= nx;
      a37         <= a36;
      fl37.azero  <= a36 == '0;
      fl37.neg_y  <= pvy36[63];
      fl37.neg_x  <= !pvx36[63] && (pvx36 != '0);
      fl37.ovf_y  <= ny[63:32] >= a36;
      fl37.ovf_x  <= nx[63:32] >= a36;
    end
  end

  logic [31:0] qy69, qx69;
  vel_flags_t  fl69;

  tmls_div #(.ND(64), .DW(32), .QW(32)) u_div_vx (
    .clk(clk), .en(en), .n(ny37), .d(a37), .q(qy69)
  );

  tmls_div #(.ND(64), .DW(32), .QW(32)) u_div_vy (
    .clk(clk), .en(en), .n(nx37), .d(a37), .q(qx69)
  );

  tmls_delay #(.W($bits(vel_flags_t)), .N(32)) u_dly_flags (
    .clk(clk), .en(en), .din(fl37), .dout(fl69)
  );

  // Stage 70: signed, saturated velocities; zero on the axis.
  logic [31:0] vx70, vy70;

  always_ff @(posedge clk) begin
    if (en) begin
      vx70 <= fl69.azero ? '0 : velsat(qy69, fl69.neg_y, fl69.ovf_y);
      vy70 <= fl69.azero ? '0 : velsat(qx69, fl69.neg_x, fl69.ovf_x);
    end
  end

  logic [31:0] vx84, vy84;

  tmls_delay #(.W(64), .N(14 + FRAC_BITS)) u_dly_vel (
    .clk(clk), .en(en), .din({vx70, vy70}), .dout({vx84, vy84})
  );

  logic [30:0] vol84;

  tmls_delay #(.W(31), .N(83 + FRAC_BITS)) u_dly_vol (
    .clk(clk), .en(en), .din(vol1), .dout(vol84)
  );

  logic in87;

  tmls_delay #(.W(1), .N(16 + FRAC_BITS)) u_dly_in (
    .clk(clk), .en(en), .din(in71), .dout(in87)
  );

  // Density change rho = rate * w.
  logic signed [63:0] prate;
  logic [31:0]        rho;

  always_ff @(posedge clk) begin
    if (en) begin
      prate <= {{32{rate[31]}}, rate} * {{(63 - FRAC_BITS){1'b0}}, wq};
      rho   <= qround(prate);
    end
  end

  // Source terms: rho*vol, then (rho*vel)*vol.
  logic signed [63:0] pm, px, py, pmx, pmy;
  logic [31:0]        mass86, mx86, my86, mass87;
  logic [30:0]        vol85, vol86;

  always_ff @(posedge clk) begin
    if (en) begin
      pm     <= {{32{rho[31]}}, rho} * {33'b0, vol84};
      px     <= {{32{rho[31]}}, rho} * {{32{vx84[31]}}, vx84};
      py     <= {{32{rho[31]}}, rho} * {{32{vy84[31]}}, vy84};
      vol85  <= vol84;
      mass86 <= qround(pm);
      mx86   <= qround(px);
      my86   <= qround(py);
      vol86  <= vol85;
      pmx    <= {{32{mx86[31]}}, mx86} * {33'b0, vol86};
      pmy    <= {{32{my86[31]}}, my86} * {33'b0, vol86};
      mass87 <= mass86;
    end
  end

  // Final stage: everything outside the tube reads as zero.
  logic [31:0] mass_f, mx_f, my_f;
  logic        in_f;

  always_ff @(posedge clk) begin
    if (en) begin
      mass_f <= in87 ? mass87 : '0;
      mx_f   <= in87 ? qround(pmx) : '0;
      my_f   <= in87 ? qround(pmy) : '0;
      in_f   <= in87;
    end
  end

  // Output register and skid entry.
  logic        out_free;
  logic [31:0] skid_mass, skid_mx, skid_my;
  logic        skid_in;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_free) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (vld[LAT-1]) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_free) begin
        mass_source       <= skid_mass;
        momentum_x_source <= skid_mx;
        momentum_y_source <= skid_my;
        inside_torus      <= skid_in;
      end
    end else if (vld[LAT-1]) begin
      if (out_free) begin
        mass_source       <= mass_f;
        momentum_x_source <= mx_f;
        momentum_y_source <= my_f;
        inside_torus      <= in_f;
      end else begin
        skid_mass <= mass_f;
        skid_mx   <= mx_f;
        skid_my   <= my_f;
        skid_in   <= in_f;
      end
    end
  end

  // A held skid entry always sits behind a waiting result.
  `TMLS_ASSERT(a_skid_behind_out, clk, rst, skid_full |-> out_valid)
  // The skid entry only fills when the output is stalled.
  `TMLS_ASSERT(a_skid_fill, clk, rst, $rose(skid_full) |-> $past(out_valid && !out_ready))
  // Cells outside the tube give zero source terms.
  `TMLS_ASSERT(a_outside_zero, clk, rst,
    (out_valid && !inside_torus) |->
      (mass_source == '0 && momentum_x_source == '0 && momentum_y_source == '0))
  // Reset empties the output side.
  `TMLS_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!out_valid && !skid_full))

endmodule
`default_nettype wire
